// File: design/sgdm_pkg.sv
package sgdm_pkg;

    // Default sizing of the momentum store and datapath
    localparam int DEF_STORE_DEPTH = 4096;
    localparam int DEF_VALUE_WIDTH = 32;

    // Stream field widths
    localparam int IDX_W     = 12;
    localparam int VAL_W     = 32;
    localparam int PAYLOAD_W = IDX_W + 2 * VAL_W;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

    // Coefficient registers are unsigned Q1.16; signed copies carry one more bit
    localparam int COEF_REG_W = 17;
    localparam int COEF_W     = COEF_REG_W + 1;
    localparam int CFG_IDX_W  = 3;

    // Exact sum width before saturation to the datapath width
    localparam int SUM_W = 35;

    // Index reduction by reciprocal: quotient = (index * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Output queue sizing, deeper than the pipeline
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;

    // Reset values of the coefficient registers
    localparam logic [COEF_REG_W-1:0] LR_RESET = COEF_REG_W'(655);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 3'd0,
        CFG_WEIGHT_DECAY  = 3'd1,
        CFG_MOMENTUM      = 3'd2,
        CFG_DAMPENING     = 3'd3,
        CFG_NESTEROV      = 3'd4
    } cfg_index_t;

endpackage

// File: design/sgd_momentum_update_core.sv
// SGD with momentum (classic or Nesterov) for a stream of parameter elements. Each s_ transfer
// carries an element index, a Q16.16 weight and its gradient; each m_ transfer returns the
// updated weight, the effective gradient and the index, in input order. One element is
// accepted per cycle while no clearing pass runs and fewer than FIFO_DEPTH are in flight;
// the exception is an element whose store address (index modulo STORE_DEPTH) equals that of
// the element just ahead of it while momentum is nonzero: the buffer recurrence (multiply,
// then add and saturate) spans two pipeline stages, so that element is held in S3 until the
// one ahead has left S4. A queue of FIFO_DEPTH results decouples the two sides, so input
// keeps flowing while a result waits. The momentum buffers and their visited flags share one
// simple dual-port memory with a registered read; after reset a clearing pass writes every
// entry and s_tready stays low until it ends. Configuration writes are taken at any time but
// must only be issued while the block is idle.
module sgd_momentum_update_core #(
    parameter int STORE_DEPTH = sgdm_pkg::DEF_STORE_DEPTH,
    parameter int VALUE_WIDTH = sgdm_pkg::DEF_VALUE_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [sgdm_pkg::COEF_REG_W-1:0]  cfg_wr_data,
    // Input elements
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sgdm_pkg::TDATA_W-1:0]     s_tdata,   // element_index, weight_in, gradient_in
    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sgdm_pkg::TDATA_W-1:0]     m_tdata    // weight_out, gradient_out, index_out
);
    import sgdm_pkg::*;

    localparam int DW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int PW = DW + COEF_W;
    localparam int RW = PW - 16;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam bit ADDR_REDUCE = (STORE_DEPTH < (1 << IDX_W));
    localparam int RECIP = (1 << RECIP_SHIFT) / STORE_DEPTH;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((longint'(1) << (DW - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    // Saturate an exact sum to the datapath width
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SUM_W-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DW-1:0];
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // Round a Q16.16 x Q1.16 product back to Q16.16, half toward plus infinity
    function automatic logic signed [RW-1:0] rnd_q16(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'(32768);
        return t[PW-1:16];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COEF_REG_W-1:0] lr_reg;
    logic [COEF_REG_W-1:0] wd_reg;
    logic [COEF_REG_W-1:0] mom_reg;
    logic [COEF_REG_W-1:0] damp_reg;
    logic                  nest_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg   <= LR_RESET;
            wd_reg   <= '0;
            mom_reg  <= '0;
            damp_reg <= '0;
            nest_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_LEARNING_RATE: lr_reg   <= cfg_wr_data;
                CFG_WEIGHT_DECAY:  wd_reg   <= cfg_wr_data;
                CFG_MOMENTUM:      mom_reg  <= cfg_wr_data;
                CFG_DAMPENING:     damp_reg <= cfg_wr_data;
                CFG_NESTEROV:      nest_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic signed [COEF_W-1:0] lr_coef;
    logic signed [COEF_W-1:0] wd_coef;
    logic signed [COEF_W-1:0] mom_coef;
    logic signed [COEF_W-1:0] keep_coef;
    logic                     mom_on;

    assign lr_coef   = signed'({1'b0, lr_reg});
    assign wd_coef   = signed'({1'b0, wd_reg});
    assign mom_coef  = signed'({1'b0, mom_reg});
    assign keep_coef = COEF_W'(65536) - signed'({1'b0, damp_reg});
    assign mom_on    = (mom_reg != '0);

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                     s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [IDX_W-1:0]         s5_idx_reg, s6_idx_reg, s7_idx_reg, s8_idx_reg;
    logic signed [DW-1:0]     s1_w_reg, s2_w_reg, s3_w_reg, s4_w_reg;
    logic signed [DW-1:0]     s5_w_reg, s6_w_reg, s7_w_reg, s8_w_reg;
    logic signed [DW-1:0]     s1_g_reg, s2_g_reg;
    logic signed [PW-1:0]     s2_p_wd_reg;
    logic [IDX_W-1:0]         s2_quot_reg;
    logic [AW-1:0]            s3_addr_reg, s4_addr_reg, s5_addr_reg;
    logic signed [DW-1:0]     s3_g1_reg, s4_g1_reg, s5_g1_reg, s6_g1_reg;
    logic signed [PW-1:0]     s4_p_old_reg, s4_p_new_reg;
    logic                     s4_hit_reg;
    logic signed [DW-1:0]     s5_buf_reg, s6_buf_reg;
    logic signed [PW-1:0]     s6_p_nest_reg;
    logic signed [DW-1:0]     s7_g2_reg, s8_g2_reg;
    logic signed [PW-1:0]     s8_p_lr_reg;

    // Momentum store: visited flag on top of the buffer value
    logic [DW:0]              store_mem [STORE_DEPTH];
    logic [DW:0]              rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic [DW:0]              mem_wd;

    // Clearing pass after reset
    logic                     clr_active_reg;
    logic [AW-1:0]            clr_addr_reg;

    // Output queue and credit count
    logic [PAYLOAD_W-1:0]     fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]         fifo_cnt_reg, fifo_cnt_next;
    logic [FIFO_AW:0]         inflight_reg, inflight_next;

    // ------------------------------------------------------------------
    // Input unpack and saturation
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]         in_idx;
    logic signed [DW-1:0]     in_w, in_g;
    logic                     s_accept;
    logic                     hazard;
    logic                     front_adv;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_w   = sat_dw(SUM_W'(signed'(s_tdata[IDX_W+VAL_W-1:IDX_W])));
    assign in_g   = sat_dw(SUM_W'(signed'(s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W])));

    // Hold the front when the element in S3 needs the buffer S4 is computing
    assign hazard    = s3_valid_reg && s4_valid_reg && mom_on && (s3_addr_reg == s4_addr_reg);
    assign front_adv = !hazard;
    assign s_tready  = !clr_active_reg && front_adv && (inflight_reg < (FIFO_AW+1)'(FIFO_DEPTH));
    assign s_accept  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Stage logic
    // ------------------------------------------------------------------
    // S1: weight decay product, index quotient
    logic signed [PW-1:0]          s1_p_wd;
    logic [IDX_W+RECIP_W-1:0]      s1_qfull;
    assign s1_p_wd  = s1_w_reg * wd_coef;
    assign s1_qfull = (IDX_W+RECIP_W)'(s1_idx_reg) * (IDX_W+RECIP_W)'(RECIP);

    // S2: decayed gradient, store address
    logic signed [DW-1:0]     s2_g1;
    logic [31:0]              s2_qd, s2_rem, s2_rem_fix;
    logic [AW-1:0]            s2_addr;
    assign s2_g1      = sat_dw(SUM_W'(s2_g_reg) + SUM_W'(rnd_q16(s2_p_wd_reg)));
    assign s2_qd      = 32'(s2_quot_reg) * 32'(STORE_DEPTH);
    assign s2_rem     = 32'(s2_idx_reg) - s2_qd;
    assign s2_rem_fix = (s2_rem >= 32'(STORE_DEPTH)) ? s2_rem - 32'(STORE_DEPTH) : s2_rem;
    assign s2_addr    = ADDR_REDUCE ? AW'(s2_rem_fix) : AW'(s2_idx_reg);

    // Read the element in S2, or re-read for S3 while it is held
    assign rd_addr = hazard ? s3_addr_reg : s2_addr;

    // S3: old buffer with forwarding from the element that wrote last cycle
    logic                     s3_fwd;
    logic signed [DW-1:0]     s3_old;
    logic                     s3_hit;
    logic signed [PW-1:0]     s3_p_old, s3_p_new;
    assign s3_fwd   = s5_valid_reg && (s5_addr_reg == s3_addr_reg);
    assign s3_old   = s3_fwd ? s5_buf_reg : signed'(rd_data_reg[DW-1:0]);
    assign s3_hit   = s3_fwd || rd_data_reg[DW];
    assign s3_p_old = s3_old * mom_coef;
    assign s3_p_new = s3_g1_reg * keep_coef;

    // S4: new buffer, written back
    logic signed [DW-1:0]     s4_buf;
    assign s4_buf = s4_hit_reg
        ? sat_dw(SUM_W'(rnd_q16(s4_p_old_reg)) + SUM_W'(rnd_q16(s4_p_new_reg)))
        : s4_g1_reg;

    assign mem_we = clr_active_reg || (s4_valid_reg && mom_on);
    assign mem_wa = clr_active_reg ? clr_addr_reg : s4_addr_reg;
    assign mem_wd = clr_active_reg ? '0 : {1'b1, s4_buf};

    // S5: Nesterov look-ahead product
    logic signed [PW-1:0]     s5_p_nest;
    assign s5_p_nest = s5_buf_reg * mom_coef;

    // S6: effective gradient
    logic signed [DW-1:0]     s6_g2;
    always_comb begin
        if (!mom_on) begin
            s6_g2 = s6_g1_reg;
        end else if (nest_reg) begin
            s6_g2 = sat_dw(SUM_W'(s6_g1_reg) + SUM_W'(rnd_q16(s6_p_nest_reg)));
        end else begin
            s6_g2 = s6_buf_reg;
        end
    end

    // S7: step product
    logic signed [PW-1:0]     s7_p_lr;
    assign s7_p_lr = s7_g2_reg * lr_coef;

    // S8: updated weight, packed for the queue
    logic signed [DW-1:0]     s8_wout;
    logic [PAYLOAD_W-1:0]     s8_payload;
    assign s8_wout    = sat_dw(SUM_W'(s8_w_reg) - SUM_W'(rnd_q16(s8_p_lr_reg)));
    assign s8_payload = {s8_idx_reg, VAL_W'(s8_g2_reg), VAL_W'(s8_wout)};

    // ------------------------------------------------------------------
    // Momentum store
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic m_pop;
    assign m_pop         = m_tvalid && m_tready;
    assign fifo_cnt_next = fifo_cnt_reg + (FIFO_AW+1)'(s8_valid_reg) - (FIFO_AW+1)'(m_pop);
    assign inflight_next = inflight_reg + (FIFO_AW+1)'(s_accept) - (FIFO_AW+1)'(m_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            s6_valid_reg   <= 1'b0;
            s7_valid_reg   <= 1'b0;
            s8_valid_reg   <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_cnt_reg   <= '0;
            inflight_reg   <= '0;
        end else begin
            // Hold the front stages during a hazard, drop a bubble into S4
            if (front_adv) begin
                s1_valid_reg <= s_accept;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            s4_valid_reg <= s3_valid_reg && !hazard;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;

            // Advance the clearing pass
            if (clr_active_reg) begin
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end

            // Queue pointers
            if (s8_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
            inflight_reg <= inflight_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (front_adv) begin
            s1_idx_reg  <= in_idx;
            s1_w_reg    <= in_w;
            s1_g_reg    <= in_g;

            s2_idx_reg  <= s1_idx_reg;
            s2_w_reg    <= s1_w_reg;
            s2_g_reg    <= s1_g_reg;
            s2_p_wd_reg <= s1_p_wd;
            s2_quot_reg <= s1_qfull[RECIP_SHIFT+IDX_W-1:RECIP_SHIFT];

            s3_idx_reg  <= s2_idx_reg;
            s3_addr_reg <= s2_addr;
            s3_w_reg    <= s2_w_reg;
            s3_g1_reg   <= s2_g1;
        end

        s4_idx_reg    <= s3_idx_reg;
        s4_addr_reg   <= s3_addr_reg;
        s4_w_reg      <= s3_w_reg;
        s4_g1_reg     <= s3_g1_reg;
        s4_p_old_reg  <= s3_p_old;
        s4_p_new_reg  <= s3_p_new;
        s4_hit_reg    <= s3_hit;

        s5_idx_reg    <= s4_idx_reg;
        s5_addr_reg   <= s4_addr_reg;
        s5_w_reg      <= s4_w_reg;
        s5_g1_reg     <= s4_g1_reg;
        s5_buf_reg    <= s4_buf;

        s6_idx_reg    <= s5_idx_reg;
        s6_w_reg      <= s5_w_reg;
        s6_g1_reg     <= s5_g1_reg;
        s6_buf_reg    <= s5_buf_reg;
        s6_p_nest_reg <= s5_p_nest;

        s7_idx_reg    <= s6_idx_reg;
        s7_w_reg      <= s6_w_reg;
        s7_g2_reg     <= s6_g2;

        s8_idx_reg    <= s7_idx_reg;
        s8_w_reg      <= s7_w_reg;
        s8_g2_reg     <= s7_g2_reg;
        s8_p_lr_reg   <= s7_p_lr;

        // Push finished results
        if (s8_valid_reg) begin
            fifo_mem[wr_ptr_reg] <= s8_payload;
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {(TDATA_W-PAYLOAD_W)'(0), fifo_mem[rd_ptr_reg]};

endmodule
